>>> sv/lpa_pkg.sv
package lpa_pkg;

  localparam int LEASE_DEPTH = 64;
  localparam int CNT_W       = $clog2(LEASE_DEPTH + 1);
  localparam int MAC_W       = 48;
  localparam int ADDR_W      = 32;
  localparam int STAT_W      = 2;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  localparam logic [STAT_W-1:0] LEASE_EXISTING  = 2'd0;
  localparam logic [STAT_W-1:0] LEASE_NEW       = 2'd1;
  localparam logic [STAT_W-1:0] LEASE_EXHAUSTED = 2'd2;

  localparam logic CFG_POOL_START = 1'b0;
  localparam logic CFG_POOL_END   = 1'b1;

  localparam logic [7:0] HOST_BCAST = 8'hFF;
  localparam logic [7:0] HOST_PRE   = 8'hFE;

  // search token walking down the cell row
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [ADDR_W-1:0] addr;
  } tok_t;

  // append request broadcast to all cells
  typedef struct packed {
    logic              en;
    logic [CNT_W-1:0]  idx;
    logic [MAC_W-1:0]  mac;
    logic [ADDR_W-1:0] addr;
  } wr_t;

  // next pool address: step by one, skip host bytes 0 and 255
  function automatic logic [ADDR_W-1:0] advance_addr(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] inc;
    begin
      if (a[7:0] == HOST_BCAST) begin
        inc = ADDR_W'(2);
      end else if (a[7:0] == HOST_PRE) begin
        inc = ADDR_W'(3);
      end else begin
        inc = ADDR_W'(1);
      end
      advance_addr = a + inc;
    end
  endfunction

endpackage

>>> sv/lpa_cell.sv
module lpa_cell
  import lpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CNT_W-1:0]  cell_idx_i,
  input  logic [CNT_W-1:0]  count_i,
  input  logic [MAC_W-1:0]  mac_i,
  input  wr_t               wr_i,
  input  tok_t              tok_i,
  output tok_t              tok_o
);

  logic [MAC_W-1:0]  mac_q;
  logic [ADDR_W-1:0] addr_q;
  tok_t              tok_q;
  tok_t              tok_d;
  logic              occupied;

  assign occupied = cell_idx_i < count_i;

  always_comb begin
    tok_d = tok_i;
    // first match wins: keep an earlier hit untouched
    if (tok_i.valid && !tok_i.hit && occupied && (mac_q == mac_i)) begin
      tok_d.hit  = 1'b1;
      tok_d.addr = addr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.idx == cell_idx_i)) begin
      mac_q  <= wr_i.mac;
      addr_q <= wr_i.addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

>>> sv/lpa_ctrl.sv
module lpa_ctrl
  import lpa_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [ADDR_W-1:0]      cfg_data_i,
  input  logic                   s_tvalid_i,
  output logic                   s_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  output logic [OUT_TDATA_W-1:0] m_tdata_o,
  output tok_t                   inj_o,
  input  tok_t                   tail_i,
  output logic [MAC_W-1:0]       mac_o,
  output logic [CNT_W-1:0]       count_o,
  output wr_t                    wr_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [ADDR_W-1:0] pool_start_q, pool_end_q;
  logic [ADDR_W-1:0] next_q, next_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [MAC_W-1:0]  mac_q;
  logic              inj_q;
  logic              hit_q;
  logic [ADDR_W-1:0] hit_addr_q;
  logic              out_valid_q, out_valid_d;
  logic [ADDR_W-1:0] out_addr_q, out_addr_d;
  logic [STAT_W-1:0] out_stat_q, out_stat_d;

  logic              s_accept;
  logic              out_free;
  logic              do_decide;
  logic [ADDR_W-1:0] cand;
  logic              exhausted;

  assign s_tready_o = (state_q == ST_IDLE);
  assign s_accept   = s_tvalid_i && s_tready_o;
  assign out_free   = !out_valid_q || m_tready_i;
  assign do_decide  = (state_q == ST_DECIDE) && out_free;
  assign cand       = (count_q == '0) ? pool_start_q : next_q;
  assign exhausted  = (count_q >= CNT_W'(LEASE_DEPTH)) || (cand > pool_end_q);

  always_comb begin
    state_d     = state_q;
    next_d      = next_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !m_tready_i;
    out_addr_d  = out_addr_q;
    out_stat_d  = out_stat_q;
    wr_o.en     = 1'b0;
    wr_o.idx    = count_q;
    wr_o.mac    = mac_q;
    wr_o.addr   = cand;
    case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tail_i.valid) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // hold until the output register can take the result
        if (do_decide) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          if (hit_q) begin
            out_addr_d = hit_addr_q;
            out_stat_d = LEASE_EXISTING;
          end else if (exhausted) begin
            out_addr_d = '0;
            out_stat_d = LEASE_EXHAUSTED;
          end else begin
            out_addr_d = cand;
            out_stat_d = LEASE_NEW;
            wr_o.en    = 1'b1;
            count_d    = count_q + CNT_W'(1);
            next_d     = advance_addr(cand);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pool_start_q <= '0;
      pool_end_q   <= '0;
      next_q       <= '0;
      count_q      <= '0;
      inj_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_q      <= next_d;
      count_q     <= count_d;
      inj_q       <= s_accept;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_POOL_START: pool_start_q <= cfg_data_i;
          CFG_POOL_END:   pool_end_q   <= cfg_data_i;
          default:        pool_end_q   <= pool_end_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      mac_q <= s_tdata_i[MAC_W-1:0];
    end
    if ((state_q == ST_SCAN) && tail_i.valid) begin
      hit_q      <= tail_i.hit;
      hit_addr_q <= tail_i.addr;
    end
    out_addr_q <= out_addr_d;
    out_stat_q <= out_stat_d;
  end

  assign inj_o.valid = inj_q;
  assign inj_o.hit   = 1'b0;
  assign inj_o.addr  = '0;
  assign mac_o       = mac_q;
  assign count_o     = count_q;
  assign m_tvalid_o  = out_valid_q;
  assign m_tdata_o   = {{(OUT_TDATA_W - ADDR_W - STAT_W){1'b0}}, out_stat_q, out_addr_q};

endmodule

>>> sv/lease_pool_allocator_top.sv
// Lease pool allocator.
// Input stream: one beat per request, s_axis_tdata[47:0] = client MAC.
// Output stream: one beat per request, m_axis_tdata[31:0] = leased address,
// [33:32] = status (0 existing lease, 1 new lease, 2 pool or table exhausted).
// Configuration: cfg_we_i with cfg_idx_i 0 writes pool_start, 1 writes
// pool_end; write only while no request is in flight.
// For each request the token launches at the accepting edge, then advances
// one cell per cycle along the row of lease cells; the tail result is
// registered into the decide step, which loads the output register. One
// request is in flight at a time. s_axis_tready is high only while the
// controller is idle, so a new request can be taken while the previous
// result still waits in the output register. If that register is still
// full when the next decision is due, the block holds in the decide step
// until the receiver takes the waiting beat.
// Reset empties the table (lease count zero), clears both pool registers
// and the output valid flag. Leases are never released.
module lease_pool_allocator_top
  import lpa_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [ADDR_W-1:0]      cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [47:0] client_mac
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [31:0] assigned_address, [33:32] lease_status
);

  tok_t             chain [LEASE_DEPTH+1];
  logic [MAC_W-1:0] mac;
  logic [CNT_W-1:0] count;
  wr_t              wr;

  lpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .inj_o      (chain[0]),
    .tail_i     (chain[LEASE_DEPTH]),
    .mac_o      (mac),
    .count_o    (count),
    .wr_o       (wr)
  );

  for (genvar g = 0; g < LEASE_DEPTH; g++) begin : g_cell
    lpa_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (CNT_W'(g)),
      .count_i    (count),
      .mac_i      (mac),
      .wr_i       (wr),
      .tok_i      (chain[g]),
      .tok_o      (chain[g+1])
    );
  end

endmodule
